[rtl/ssd_pkg.sv]
// ============================================================================
// ssd_pkg: shared types for the signed shift-subtract divider
// Control word that travels alongside the data through every pipeline stage.
// ============================================================================
package ssd_pkg;

  // Per-stage control: word valid, result sign, divisor was zero.
  typedef struct packed {
    logic vld;
    logic neg;
    logic dz;
  } ssd_ctl_t;

endpackage : ssd_pkg

[rtl/ssd_operand_if.sv]
// ============================================================================
// ssd_operand_if: operand channel of the signed divider
// Valid/ready channel that carries one dividend/divisor word.
// ============================================================================
interface ssd_operand_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] numerator;
  logic signed [DATA_WIDTH-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface : ssd_operand_if

[rtl/ssd_result_if.sv]
// ============================================================================
// ssd_result_if: result channel of the signed divider
// Valid/ready channel that carries one quotient word and the zero-divisor flag.
// ============================================================================
interface ssd_result_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quotient_out;
  logic                         zero_divisor;

  modport source (output valid, output quotient_out, output zero_divisor, input ready);
  modport sink   (input valid, input quotient_out, input zero_divisor, output ready);
endinterface : ssd_result_if

[rtl/ssd_prep.sv]
// ============================================================================
// ssd_prep: operand conditioning stage
// Takes magnitudes of both operands, registers them with sign and zero flags.
// ============================================================================
module ssd_prep #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vld_in,
  input  logic [DATA_WIDTH-1:0] numerator,
  input  logic [DATA_WIDTH-1:0] denominator,
  output logic [DATA_WIDTH-1:0] rem,
  output logic [DATA_WIDTH-1:0] dmag,
  output ssd_pkg::ssd_ctl_t     ctl
);
  import ssd_pkg::*;

  logic                  n_neg;
  logic                  d_neg;
  logic [DATA_WIDTH-1:0] n_mag;
  logic [DATA_WIDTH-1:0] d_mag;

  assign n_neg = numerator[DATA_WIDTH-1];
  assign d_neg = denominator[DATA_WIDTH-1];
  assign n_mag = n_neg ? (~numerator + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : numerator;
  assign d_mag = d_neg ? (~denominator + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : denominator;

  // Only the valid bit is reset; payload just follows the enable.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (en) begin
      ctl.vld <= vld_in;
    end
    if (en) begin
      rem     <= n_mag;
      dmag    <= d_mag;
      ctl.neg <= n_neg ^ d_neg;
      ctl.dz  <= (denominator == '0);
    end
  end

endmodule : ssd_prep

[rtl/ssd_cell.sv]
// ============================================================================
// ssd_cell: one quotient-bit cell of the divider chain
// Tests the shifted divisor against the partial remainder at bit BIT,
// subtracts when it fits, and hands the word to the next cell.
// ============================================================================
module ssd_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int BIT        = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] dmag_in,
  input  logic [DATA_WIDTH-1:0] q_in,
  input  ssd_pkg::ssd_ctl_t     ctl_in,
  output logic [DATA_WIDTH-1:0] rem,
  output logic [DATA_WIDTH-1:0] dmag,
  output logic [DATA_WIDTH-1:0] q,
  output ssd_pkg::ssd_ctl_t     ctl
);
  import ssd_pkg::*;

  logic [DATA_WIDTH-1:0] rem_shift;
  logic                  fits;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] q_next;

  assign rem_shift = rem_in >> BIT;
  assign fits      = (rem_shift >= dmag_in);
  assign rem_next  = fits ? (rem_in - (dmag_in << BIT)) : rem_in;

  always_comb begin
    q_next      = q_in;
    q_next[BIT] = fits;
  end

  // Only the valid bit is reset; payload just follows the enable.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (en) begin
      ctl.vld <= ctl_in.vld;
    end
    if (en) begin
      rem     <= rem_next;
      dmag    <= dmag_in;
      q       <= q_next;
      ctl.neg <= ctl_in.neg;
      ctl.dz  <= ctl_in.dz;
    end
  end

endmodule : ssd_cell

[rtl/signed_shift_subtract_divider.sv]
// ============================================================================
// signed_shift_subtract_divider: pipelined signed restoring divider
// Row of quotient-bit cells between a magnitude stage and a sign stage.
// ============================================================================
// Usage:
//   operands (sink): one word = numerator, denominator, signed DATA_WIDTH bits.
//   results (source): one word = quotient_out (truncated toward zero, low
//   DATA_WIDTH bits, so MIN / -1 wraps to MIN) and zero_divisor. A zero
//   divisor yields -1, or 1 for a negative numerator, with the flag set.
// Timing:
//   A word passes one magnitude stage, one cell per quotient bit and one
//   sign/output register from accept to result valid. Throughput is one
//   word per cycle unless the receiver stalls; every stage holds its own word.
// Stall:
//   The whole row advances together whenever the output register is empty
//   or being taken. When the receiver stalls, every stage holds and
//   operands.ready drops, so nothing is lost.
// Reset:
//   rst (synchronous, active high) clears all stage valid bits; payload
//   registers are not reset. The block is ready the cycle after reset.
// ============================================================================
module signed_shift_subtract_divider #(
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  ssd_operand_if.sink  operands,
  ssd_result_if.source results
);
  import ssd_pkg::*;

  localparam int NCELL = DATA_WIDTH;

  // Advance the whole chain when the output slot is free or draining.
  logic advance;
  assign advance        = !results.valid || results.ready;
  assign operands.ready = advance;

  // Stage k feeds cell k; stage 0 is the magnitude register.
  logic [DATA_WIDTH-1:0] rem_s  [0:NCELL];
  logic [DATA_WIDTH-1:0] dmag_s [0:NCELL];
  logic [DATA_WIDTH-1:0] q_s    [0:NCELL];
  ssd_ctl_t              ctl_s  [0:NCELL];

  ssd_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .vld_in      (operands.valid),
    .numerator   (operands.numerator),
    .denominator (operands.denominator),
    .rem         (rem_s[0]),
    .dmag        (dmag_s[0]),
    .ctl         (ctl_s[0])
  );

  // Quotient starts empty; each cell fills in its own bit.
  assign q_s[0] = '0;

  // Cell k decides quotient bit DATA_WIDTH-1-k, highest bit first.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    ssd_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .BIT        (DATA_WIDTH - 1 - k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .rem_in  (rem_s[k]),
      .dmag_in (dmag_s[k]),
      .q_in    (q_s[k]),
      .ctl_in  (ctl_s[k]),
      .rem     (rem_s[k+1]),
      .dmag    (dmag_s[k+1]),
      .q       (q_s[k+1]),
      .ctl     (ctl_s[k+1])
    );
  end

  // Apply the sign rule on the magnitude quotient; wrap falls out naturally.
  logic [DATA_WIDTH-1:0] q_fin;
  logic [DATA_WIDTH-1:0] q_signed;
  assign q_fin    = q_s[NCELL];
  assign q_signed = ctl_s[NCELL].neg ? (~q_fin + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : q_fin;

  // Output register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= ctl_s[NCELL].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.quotient_out <= q_signed;
      results.zero_divisor <= ctl_s[NCELL].dz;
    end
  end

  // The final remainder is not part of the result.
  logic unused_rem;
  assign unused_rem = ^{rem_s[NCELL], dmag_s[NCELL]};

endmodule : signed_shift_subtract_divider

[rtl/ssd_checker.sv]
// ============================================================================
// ssd_checker: port-level checks for the signed divider
// Watches the top-level channels over time; attached by bind.
// ============================================================================
module ssd_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] quotient_out,
  input logic                  zero_divisor
);

  localparam logic [DATA_WIDTH-1:0] ONE   = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [DATA_WIDTH-1:0] M_ONE = {DATA_WIDTH{1'b1}};

  // Stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient_out) && $stable(zero_divisor))
    else $error("result word changed while stalled");

  // A free output slot always lets operands in.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("operands blocked with output slot empty");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // Zero divisor gives +1 or -1.
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_divisor |-> (quotient_out == ONE) || (quotient_out == M_ONE))
    else $error("zero-divisor quotient not +/-1");

endmodule : ssd_checker

bind signed_shift_subtract_divider ssd_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_ssd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (operands.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .quotient_out (results.quotient_out),
  .zero_divisor (results.zero_divisor)
);
